### hw/rtl/fbdr_pkg.sv
// Shared constants, codes and types of the framebuffer dirty-rectangle tracker.
package fbdr_pkg;

  // Frame store geometry
  localparam int unsigned BUF_WIDTH  = 128;
  localparam int unsigned BUF_HEIGHT = 128;
  localparam int unsigned PIXEL_BITS = 16;
  localparam int unsigned X_W        = $clog2(BUF_WIDTH);
  localparam int unsigned Y_W        = $clog2(BUF_HEIGHT);
  localparam int unsigned ADDR_W     = X_W + Y_W;

  // Field widths
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned SIZE_W     = 8;
  localparam int unsigned COLOR_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL  = 3'd0,
    KIND_FILL   = 3'd1,
    KIND_WINDOW = 3'd2,
    KIND_BITMAP = 3'd3,
    KIND_READ   = 3'd4,
    KIND_FLUSH  = 3'd5
  } kind_e;

  // Result kinds
  localparam logic RES_READ   = 1'b0;
  localparam logic RES_WINDOW = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRTY_EN = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   x_pos;
    logic [POS_W-1:0]   y_pos;
    logic [SIZE_W-1:0]  rect_width;
    logic [SIZE_W-1:0]  rect_height;
    logic [COLOR_W-1:0] color;
  } item_t;

  // Controller -> datapath
  typedef struct packed {
    logic take;       // item accepted this cycle
    logic fill_step;  // write next pixel of the fill
    logic resp_load;  // move read data or flush window into the output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_fill;    // offered item is a nonempty fill
    logic in_resp;    // offered item is a read or a flush
    logic fill_last;  // fill is at its last pixel
    logic out_free;   // output register can take a result this cycle
  } stat_t;

endpackage

### hw/rtl/fbdr_if.sv
// Handshake channels of the tracker: input items, result items, configuration writes.
interface fbdr_in_if;
  import fbdr_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [POS_W-1:0]    x_pos;
  logic [POS_W-1:0]    y_pos;
  logic [SIZE_W-1:0]   rect_width;
  logic [SIZE_W-1:0]   rect_height;
  logic [COLOR_W-1:0]  color;
  modport source (output valid, kind, x_pos, y_pos, rect_width, rect_height, color,
                  input ready);
  modport sink   (input valid, kind, x_pos, y_pos, rect_width, rect_height, color,
                  output ready);
endinterface

interface fbdr_out_if;
  import fbdr_pkg::*;
  logic                valid;
  logic                ready;
  logic                result_kind;
  logic [COLOR_W-1:0]  pixel_value;
  logic [POS_W-1:0]    win_x;
  logic [POS_W-1:0]    win_y;
  logic [SIZE_W-1:0]   win_w;
  logic [SIZE_W-1:0]   win_h;
  modport source (output valid, result_kind, pixel_value, win_x, win_y, win_w, win_h,
                  input ready);
  modport sink   (input valid, result_kind, pixel_value, win_x, win_y, win_w, win_h,
                  output ready);
endinterface

interface fbdr_cfg_if;
  import fbdr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/fbdr_ctrl.sv
// Sequencing state machine of the tracker: accept, fill sweep, result hand-off.
module fbdr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  fbdr_pkg::stat_t stat_i,
  output fbdr_pkg::cmd_t  cmd_o
);
  import fbdr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (stat_i.in_fill) begin
            state_d = S_FILL;
          end else if (stat_i.in_resp) begin
            state_d = S_RESP;
          end
        end
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (stat_i.fill_last) begin
          state_d = S_IDLE;
        end
      end
      S_RESP: begin
        // wait for room in the output register
        if (stat_i.out_free) begin
          cmd_o.resp_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.take, cmd_o.fill_step, cmd_o.resp_load}))
    else $error("more than one datapath command in a cycle");

  a_fill_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.take && stat_i.in_fill) |=> (state_q == S_FILL && !in_ready_o))
    else $error("fill did not start its sweep");

endmodule

### hw/rtl/fbdr_dp.sv
// Datapath of the tracker: frame store, dirty box, bitmap cursor, fill counters, result register.
module fbdr_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fbdr_pkg::item_t item_i,
  input  fbdr_pkg::cmd_t  cmd_i,
  output fbdr_pkg::stat_t stat_o,
  fbdr_cfg_if.sink        cfg_i,
  fbdr_out_if.source      out_o
);
  import fbdr_pkg::*;

  localparam logic [SIZE_W-1:0] BUF_W_C = SIZE_W'(BUF_WIDTH);
  localparam logic [SIZE_W-1:0] BUF_H_C = SIZE_W'(BUF_HEIGHT);

  // configuration
  logic [CFG_DATA_W-1:0] scr_w_q, scr_h_q;
  logic                  dirty_en_q;

  // dirty box
  logic              box_valid_q, box_valid_d;
  logic [SIZE_W-1:0] box_l_q, box_t_q, box_r_q, box_b_q;
  logic [SIZE_W-1:0] box_l_d, box_t_d, box_r_d, box_b_d;

  // bitmap window and cursor
  logic [POS_W-1:0]  win_x_q, win_y_q, win_x_d, win_y_d;
  logic [SIZE_W-1:0] win_w_q, win_h_q, win_w_d, win_h_d;
  logic [SIZE_W-1:0] cur_col_q, cur_row_q, cur_col_d, cur_row_d;

  // fill sweep
  logic [POS_W-1:0]   fill_x_q, fill_y_q;
  logic [SIZE_W-1:0]  fill_w_q, fill_h_q, fill_col_q, fill_row_q;
  logic [COLOR_W-1:0] fill_color_q;

  // frame store
  logic [PIXEL_BITS-1:0] mem [BUF_WIDTH*BUF_HEIGHT];
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [PIXEL_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [PIXEL_BITS-1:0] rd_data_q;
  logic                  rd_in_screen_q;
  logic                  resp_read_q;

  // result register
  logic               out_valid_q, out_valid_d;
  logic               res_kind_q;
  logic [COLOR_W-1:0] res_pixel_q;
  logic [POS_W-1:0]   res_x_q, res_y_q;
  logic [SIZE_W-1:0]  res_w_q, res_h_q;

  logic is_pixel, is_fill, is_window, is_bitmap, is_read, is_flush;
  logic size_ok, win_open;

  assign is_pixel  = item_i.kind == KIND_PIXEL;
  assign is_fill   = item_i.kind == KIND_FILL;
  assign is_window = item_i.kind == KIND_WINDOW;
  assign is_bitmap = item_i.kind == KIND_BITMAP;
  assign is_read   = item_i.kind == KIND_READ;
  assign is_flush  = item_i.kind == KIND_FLUSH;
  assign size_ok   = (item_i.rect_width != '0) && (item_i.rect_height != '0);
  assign win_open  = (win_w_q != '0) && (win_h_q != '0);

  assign stat_o.in_fill   = is_fill && size_ok;
  assign stat_o.in_resp   = is_read || is_flush;
  assign stat_o.fill_last = (fill_col_q == fill_w_q - 1'b1) && (fill_row_q == fill_h_q - 1'b1);
  assign stat_o.out_free  = !out_valid_q || out_o.ready;

  // configuration port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q    <= BUF_W_C;
      scr_h_q    <= BUF_H_C;
      dirty_en_q <= 1'b1;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_SCREEN_W) begin
        scr_w_q <= cfg_i.data;
      end
      if (cfg_i.index == CFG_SCREEN_H) begin
        scr_h_q <= cfg_i.data;
      end
      if (cfg_i.index == CFG_DIRTY_EN) begin
        dirty_en_q <= cfg_i.data[0];
      end
    end
  end

  // effective screen size
  logic [SIZE_W-1:0] scr_w_eff, scr_h_eff;
  assign scr_w_eff = (scr_w_q > BUF_W_C) ? BUF_W_C : scr_w_q;
  assign scr_h_eff = (scr_h_q > BUF_H_C) ? BUF_H_C : scr_h_q;

  // bitmap and fill pixel positions, one bit wider to catch overflow of the buffer
  logic [SIZE_W:0] bmp_px, bmp_py, fill_px, fill_py;
  assign bmp_px  = {2'b00, win_x_q} + {1'b0, cur_col_q};
  assign bmp_py  = {2'b00, win_y_q} + {1'b0, cur_row_q};
  assign fill_px = {2'b00, fill_x_q} + {1'b0, fill_col_q};
  assign fill_py = {2'b00, fill_y_q} + {1'b0, fill_row_q};

  // write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {item_i.y_pos[Y_W-1:0], item_i.x_pos[X_W-1:0]};
    wr_data = item_i.color[PIXEL_BITS-1:0];
    if (cmd_i.fill_step) begin
      wr_en   = (fill_px < (SIZE_W+1)'(BUF_WIDTH)) && (fill_py < (SIZE_W+1)'(BUF_HEIGHT));
      wr_addr = {fill_py[Y_W-1:0], fill_px[X_W-1:0]};
      wr_data = fill_color_q[PIXEL_BITS-1:0];
    end else if (cmd_i.take && is_pixel) begin
      wr_en   = 1'b1;
    end else if (cmd_i.take && is_bitmap && win_open) begin
      wr_en   = (bmp_px < (SIZE_W+1)'(BUF_WIDTH)) && (bmp_py < (SIZE_W+1)'(BUF_HEIGHT));
      wr_addr = {bmp_py[Y_W-1:0], bmp_px[X_W-1:0]};
    end
  end

  assign rd_en = cmd_i.take && is_read;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[{item_i.y_pos[Y_W-1:0], item_i.x_pos[X_W-1:0]}];
    end
  end

  // latch read bounds and response kind
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      rd_in_screen_q <= ({1'b0, item_i.x_pos} < scr_w_eff) && ({1'b0, item_i.y_pos} < scr_h_eff);
      resp_read_q    <= is_read;
    end
  end

  // fill sweep counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && is_fill) begin
      fill_x_q     <= item_i.x_pos;
      fill_y_q     <= item_i.y_pos;
      fill_w_q     <= item_i.rect_width;
      fill_h_q     <= item_i.rect_height;
      fill_color_q <= item_i.color;
      fill_col_q   <= '0;
      fill_row_q   <= '0;
    end else if (cmd_i.fill_step) begin
      if (fill_col_q == fill_w_q - 1'b1) begin
        fill_col_q <= '0;
        fill_row_q <= fill_row_q + 1'b1;
      end else begin
        fill_col_q <= fill_col_q + 1'b1;
      end
    end
  end

  // bitmap window and cursor
  always_comb begin
    win_x_d   = win_x_q;
    win_y_d   = win_y_q;
    win_w_d   = win_w_q;
    win_h_d   = win_h_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    if (cmd_i.take && is_window) begin
      cur_col_d = '0;
      cur_row_d = '0;
      if (size_ok) begin
        win_x_d = item_i.x_pos;
        win_y_d = item_i.y_pos;
        win_w_d = item_i.rect_width;
        win_h_d = item_i.rect_height;
      end else begin
        win_x_d = '0;
        win_y_d = '0;
        win_w_d = '0;
        win_h_d = '0;
      end
    end else if (cmd_i.take && is_bitmap && win_open) begin
      if (cur_col_q + 1'b1 == win_w_q) begin
        cur_col_d = '0;
        if (cur_row_q + 1'b1 == win_h_q) begin
          // last pixel: close the window
          cur_row_d = '0;
          win_x_d   = '0;
          win_y_d   = '0;
          win_w_d   = '0;
          win_h_d   = '0;
        end else begin
          cur_row_d = cur_row_q + 1'b1;
        end
      end else begin
        cur_col_d = cur_col_q + 1'b1;
      end
    end
  end

  // dirty box growth
  logic [SIZE_W-1:0] add_w, add_h, add_r, add_b;
  logic [SIZE_W:0]   add_r_raw, add_b_raw;
  logic              add_en;

  assign add_w     = is_pixel ? SIZE_W'(1) : item_i.rect_width;
  assign add_h     = is_pixel ? SIZE_W'(1) : item_i.rect_height;
  assign add_r_raw = {2'b00, item_i.x_pos} + {1'b0, add_w};
  assign add_b_raw = {2'b00, item_i.y_pos} + {1'b0, add_h};
  assign add_r     = (add_r_raw > (SIZE_W+1)'(BUF_WIDTH)) ? BUF_W_C : add_r_raw[SIZE_W-1:0];
  assign add_b     = (add_b_raw > (SIZE_W+1)'(BUF_HEIGHT)) ? BUF_H_C : add_b_raw[SIZE_W-1:0];
  assign add_en    = cmd_i.take && (is_pixel || is_fill || is_window)
                     && (add_w != '0) && (add_h != '0);

  // flush window
  logic              flush_emit;
  logic [POS_W-1:0]  fl_x, fl_y;
  logic [SIZE_W-1:0] fl_w, fl_h;

  assign flush_emit = (scr_w_eff != '0) && (scr_h_eff != '0) && (!dirty_en_q || box_valid_q);
  assign fl_x = dirty_en_q ? box_l_q[POS_W-1:0] : '0;
  assign fl_y = dirty_en_q ? box_t_q[POS_W-1:0] : '0;
  assign fl_w = dirty_en_q ? (box_r_q - box_l_q) : scr_w_eff;
  assign fl_h = dirty_en_q ? (box_b_q - box_t_q) : scr_h_eff;

  always_comb begin
    box_valid_d = box_valid_q;
    box_l_d     = box_l_q;
    box_t_d     = box_t_q;
    box_r_d     = box_r_q;
    box_b_d     = box_b_q;
    if (add_en) begin
      box_valid_d = 1'b1;
      if (!box_valid_q) begin
        box_l_d = {1'b0, item_i.x_pos};
        box_t_d = {1'b0, item_i.y_pos};
        box_r_d = add_r;
        box_b_d = add_b;
      end else begin
        if ({1'b0, item_i.x_pos} < box_l_q) box_l_d = {1'b0, item_i.x_pos};
        if ({1'b0, item_i.y_pos} < box_t_q) box_t_d = {1'b0, item_i.y_pos};
        if (add_r > box_r_q) box_r_d = add_r;
        if (add_b > box_b_q) box_b_d = add_b;
      end
    end else if (cmd_i.resp_load && !resp_read_q && flush_emit) begin
      box_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_valid_q <= 1'b0;
      box_l_q     <= '0;
      box_t_q     <= '0;
      box_r_q     <= '0;
      box_b_q     <= '0;
      win_x_q     <= '0;
      win_y_q     <= '0;
      win_w_q     <= '0;
      win_h_q     <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      box_valid_q <= box_valid_d;
      box_l_q     <= box_l_d;
      box_t_q     <= box_t_d;
      box_r_q     <= box_r_d;
      box_b_q     <= box_b_d;
      win_x_q     <= win_x_d;
      win_y_q     <= win_y_d;
      win_w_q     <= win_w_d;
      win_h_q     <= win_h_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  logic res_load;
  assign res_load    = cmd_i.resp_load && (resp_read_q || flush_emit);
  assign out_valid_d = res_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      if (resp_read_q) begin
        res_kind_q  <= RES_READ;
        res_pixel_q <= rd_in_screen_q ? COLOR_W'(rd_data_q) : '0;
        res_x_q     <= '0;
        res_y_q     <= '0;
        res_w_q     <= '0;
        res_h_q     <= '0;
      end else begin
        res_kind_q  <= RES_WINDOW;
        res_pixel_q <= '0;
        res_x_q     <= fl_x;
        res_y_q     <= fl_y;
        res_w_q     <= fl_w;
        res_h_q     <= fl_h;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = res_kind_q;
  assign out_o.pixel_value = res_pixel_q;
  assign out_o.win_x       = res_x_q;
  assign out_o.win_y       = res_y_q;
  assign out_o.win_w       = res_w_q;
  assign out_o.win_h       = res_h_q;

  a_box_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_valid_q |-> (box_l_q < box_r_q && box_t_q < box_b_q
                     && box_r_q <= BUF_W_C && box_b_q <= BUF_H_C))
    else $error("dirty box is malformed");

  a_cursor_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_open |-> (cur_col_q < win_w_q && cur_row_q < win_h_q))
    else $error("bitmap cursor left its window");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || out_o.ready))
    else $error("result register overwritten before it was taken");

endmodule

### hw/rtl/framebuffer_dirty_rect_tracker.sv
// Top level of the framebuffer dirty-rectangle tracker.
//
// The block holds a 128 x 128 frame store of 16-bit pixels and tracks the
// bounding box of everything drawn since the last flush. Items arrive one at
// a time on in_i: pixel write, rectangle fill, bitmap window (opens a window
// and marks it dirty), bitmap pixel (streams into the open window in
// row-major order), read (answers with one pixel, 0 outside the screen) and
// flush (answers with the dirty window and clears it, or the whole screen
// when dirty tracking is off; no answer if the screen, or a tracked box, is empty).
// Pixels beyond the buffer edge are dropped and the box is clipped to it.
// Timing: pixel writes, bitmap windows and bitmap pixels are done as they
// are taken; a fill then sweeps its rectangle in row-major order, since the
// store's single write port takes one pixel per cycle; a read or a flush is
// taken (a read registers its memory data), then waits for room in the output
// register and loads its result. The frame store has no reset and needs no
// clearing pass: reading a pixel that was never written returns junk.
// Configuration writes on cfg_i are taken every cycle and must only be
// issued while the block is idle.
module framebuffer_dirty_rect_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  fbdr_in_if.sink     in_i,
  fbdr_out_if.source  out_o,
  fbdr_cfg_if.sink    cfg_i
);
  import fbdr_pkg::*;

  item_t item;
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  // pack the offered item for the datapath
  assign item.kind        = in_i.kind;
  assign item.x_pos       = in_i.x_pos;
  assign item.y_pos       = in_i.y_pos;
  assign item.rect_width  = in_i.rect_width;
  assign item.rect_height = in_i.rect_height;
  assign item.color       = in_i.color;

  assign in_i.ready = in_ready;

  fbdr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fbdr_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .cmd_i  (cmd),
    .stat_o (stat),
    .cfg_i  (cfg_i),
    .out_o  (out_o)
  );

endmodule

### bench/fbdr_checker.sv
// Checker of the framebuffer dirty-rectangle tracker: predicts every result and compares it.
module fbdr_checker
  import fbdr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  fbdr_in_if   in_mon,
  fbdr_out_if  out_mon,
  fbdr_cfg_if  cfg_mon,
  output int   mismatches_o,
  output int   pending_o,
  output int   checked_o
);

  localparam int BW = BUF_WIDTH;
  localparam int BH = BUF_HEIGHT;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic               res_kind;
    logic [COLOR_W-1:0] pixel;
    logic [POS_W-1:0]   wx;
    logic [POS_W-1:0]   wy;
    logic [SIZE_W-1:0]  ww;
    logic [SIZE_W-1:0]  wh;
  } answer_t;

  logic [COLOR_W-1:0] pixels [BW*BH];
  answer_t            answers_q [$];
  bit                 box_on;
  int                 box_l, box_t, box_r, box_b;
  int                 bmp_x, bmp_y, bmp_w, bmp_h, bmp_col, bmp_row;
  int                 scr_w, scr_h;
  bit                 track_dirty;

  function automatic void report(string msg);
    if (mismatches_o < MAX_PRINTED) $display("%0t mismatch: %s", $time, msg);
    mismatches_o++;
  endfunction

  // Drop pixels beyond the buffer edge.
  function automatic void paint(int x, int y, logic [COLOR_W-1:0] c);
    if (x < BW && y < BH) pixels[y * BW + x] = c;
  endfunction

  // Grow the dirty box by a rectangle clipped to the buffer (half-open edges).
  function automatic void grow_box(int x, int y, int w, int h);
    int x1, y1;
    if (w == 0 || h == 0 || x >= BW || y >= BH) return;
    x1 = (x + w > BW) ? BW : x + w;
    y1 = (y + h > BH) ? BH : y + h;
    if (!box_on) begin
      box_l = x;
      box_t = y;
      box_r = x1;
      box_b = y1;
      box_on = 1'b1;
    end else begin
      if (x < box_l) box_l = x;
      if (y < box_t) box_t = y;
      if (x1 > box_r) box_r = x1;
      if (y1 > box_b) box_b = y1;
    end
  endfunction

  function automatic void take_item(logic [KIND_W-1:0] kind, int x, int y, int w, int h,
                                    logic [COLOR_W-1:0] c);
    int sw, sh, r, k;
    answer_t a;
    sw = (scr_w < BW) ? scr_w : BW;
    sh = (scr_h < BH) ? scr_h : BH;
    a = '0;
    case (kind)
      KIND_PIXEL: begin
        paint(x, y, c);
        grow_box(x, y, 1, 1);
      end
      KIND_FILL: begin
        if (w != 0 && h != 0) begin
          for (r = 0; r < h; r++)
            for (k = 0; k < w; k++) paint(x + k, y + r, c);
          grow_box(x, y, w, h);
        end
      end
      KIND_WINDOW: begin
        bmp_col = 0;
        bmp_row = 0;
        if (w == 0 || h == 0) begin
          bmp_w = 0;
          bmp_h = 0;
        end else begin
          bmp_x = x;
          bmp_y = y;
          bmp_w = w;
          bmp_h = h;
          grow_box(x, y, w, h);
        end
      end
      KIND_BITMAP: begin
        if (bmp_w != 0 && bmp_h != 0) begin
          paint(bmp_x + bmp_col, bmp_y + bmp_row, c);
          bmp_col++;
          if (bmp_col >= bmp_w) begin
            bmp_col = 0;
            bmp_row++;
          end
          // close the window after its last pixel
          if (bmp_row >= bmp_h) begin
            bmp_w = 0;
            bmp_h = 0;
            bmp_col = 0;
            bmp_row = 0;
          end
        end
      end
      KIND_READ: begin
        a.res_kind = RES_READ;
        if (x < sw && y < sh) a.pixel = pixels[y * BW + x];
        answers_q.push_back(a);
      end
      KIND_FLUSH: begin
        if (sw != 0 && sh != 0 && (box_on || !track_dirty)) begin
          a.res_kind = RES_WINDOW;
          if (track_dirty) begin
            a.wx = POS_W'(box_l);
            a.wy = POS_W'(box_t);
            a.ww = SIZE_W'(box_r - box_l);
            a.wh = SIZE_W'(box_b - box_t);
          end else begin
            a.ww = SIZE_W'(sw);
            a.wh = SIZE_W'(sh);
          end
          box_on = 1'b0;
          answers_q.push_back(a);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_result();
    answer_t want;
    checked_o++;
    if (answers_q.size() == 0) begin
      report($sformatf("result of kind %0d with nothing expected", out_mon.result_kind));
      return;
    end
    want = answers_q.pop_front();
    if (out_mon.result_kind !== want.res_kind)
      report($sformatf("result_kind %0d, want %0d", out_mon.result_kind, want.res_kind));
    if (out_mon.pixel_value !== want.pixel)
      report($sformatf("pixel_value %h, want %h", out_mon.pixel_value, want.pixel));
    if (out_mon.win_x !== want.wx)
      report($sformatf("win_x %0d, want %0d", out_mon.win_x, want.wx));
    if (out_mon.win_y !== want.wy)
      report($sformatf("win_y %0d, want %0d", out_mon.win_y, want.wy));
    if (out_mon.win_w !== want.ww)
      report($sformatf("win_w %0d, want %0d", out_mon.win_w, want.ww));
    if (out_mon.win_h !== want.wh)
      report($sformatf("win_h %0d, want %0d", out_mon.win_h, want.wh));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      answers_q.delete();
      box_on = 1'b0;
      box_l = 0;
      box_t = 0;
      box_r = 0;
      box_b = 0;
      bmp_x = 0;
      bmp_y = 0;
      bmp_w = 0;
      bmp_h = 0;
      bmp_col = 0;
      bmp_row = 0;
      scr_w = BW;
      scr_h = BH;
      track_dirty = 1'b1;
      mismatches_o = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_SCREEN_W: scr_w = cfg_mon.data;
          CFG_SCREEN_H: scr_h = cfg_mon.data;
          CFG_DIRTY_EN: track_dirty = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        take_item(in_mon.kind, in_mon.x_pos, in_mon.y_pos, in_mon.rect_width,
                  in_mon.rect_height, in_mon.color);
      pending_o = answers_q.size();
    end
  end

endmodule

### bench/tb_framebuffer_dirty_rect_tracker.sv
// Testbench top of the framebuffer dirty-rectangle tracker: stimulus, idling and verdict.
module tb_framebuffer_dirty_rect_tracker;
  import fbdr_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 116;
  localparam int MAX_IDLE    = 14;
  localparam int SETTLE      = 16;
  localparam int MAX_CYCLES  = 4_000_000;

  // Kind codes the block leaves unused; they must be ignored.
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int mismatches, pending, checked;
  int last_cost, items_sent, near_x, near_y;
  bit calm, hold_next;

  fbdr_in_if  in_ch ();
  fbdr_out_if out_ch ();
  fbdr_cfg_if cfg_ch ();

  framebuffer_dirty_rect_tracker u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  fbdr_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_mon      (cfg_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Wait until every expected result has come back. Sample the count on the
  // falling edge so the checker's update at the rising edge has settled, then
  // realign to a rising edge for driving.
  task automatic drain();
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Drop valid, drain the results and give a trailing fill time to finish;
  // a fill produces no result, so the drain alone says nothing about it.
  task automatic settle();
    in_ch.valid <= 1'b0;
    drain();
    repeat (SETTLE + last_cost) @(posedge clk);
  endtask

  // Offer one item after a random gap and hold it until the block takes it.
  // Keep valid high across back-to-back items so it is never lowered and
  // raised in the same step.
  task automatic send_item(logic [KIND_W-1:0] k, int x, int y, int w, int h, int c);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (hold_next && gap == 0) gap = 1;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (hold_next) begin
      drain();
      hold_next = 1'b0;
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= k;
    in_ch.x_pos       <= POS_W'(x);
    in_ch.y_pos       <= POS_W'(y);
    in_ch.rect_width  <= SIZE_W'(w);
    in_ch.rect_height <= SIZE_W'(h);
    in_ch.color       <= COLOR_W'(c);
    do @(posedge clk); while (!in_ch.ready);
    last_cost = (k == KIND_FILL) ? w * h : 0;
    items_sent++;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Reprogram the screen only while the block is idle.
  task automatic set_screen(int w, int h, int en);
    settle();
    cfg_write(CFG_SCREEN_W, w);
    cfg_write(CFG_SCREEN_H, h);
    cfg_write(CFG_DIRTY_EN, en);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly well-formed drawing: pixel writes, fills, complete bitmap
  // windows, reads near the last drawn spot and flushes; the rest is noise
  // and truncated bitmaps. Ignored noise items do not count.
  task automatic random_burst(int n);
    int drawn, pick, sel, x, y, w, h, len, i;
    drawn = 0;
    while (drawn < n) begin
      if ($urandom_range(0, 49) == 0) calm = !calm;
      if ($urandom_range(0, 32) == 0) hold_next = 1'b1;
      pick = $urandom_range(0, 99);
      x = $urandom_range(0, 127);
      y = $urandom_range(0, 127);
      w = $urandom_range(0, 128);
      h = $urandom_range(0, 128);
      if (pick < 20) begin
        send_item(KIND_PIXEL, x, y, w, h, $urandom_range(0, 65535));
        near_x = x;
        near_y = y;
        drawn++;
      end else if (pick < 35) begin
        // keep fills cheap: a fill sweeps every pixel of its rectangle
        sel = $urandom_range(0, 19);
        if (sel < 16) begin
          w = $urandom_range(1, 10);
          h = $urandom_range(1, 10);
        end else if (sel < 19) begin
          w = $urandom_range(0, 3) == 0 ? 128 : $urandom_range(1, 128);
          h = $urandom_range(1, 2);
          if ($urandom_range(0, 1) == 1) begin
            len = w;
            w = h;
            h = len;
          end
        end else begin
          x = $urandom_range(96, 127);
          y = $urandom_range(96, 127);
          w = $urandom_range(1, 40);
          h = $urandom_range(1, 40);
        end
        send_item(KIND_FILL, x, y, w, h, $urandom_range(0, 65535));
        near_x = x;
        near_y = y;
        drawn++;
      end else if (pick < 50) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          w = 128;
          h = 1;
        end else begin
          w = sel == 1 ? $urandom_range(9, 32) : $urandom_range(1, 8);
          h = $urandom_range(1, 4);
        end
        send_item(KIND_WINDOW, x, y, w, h, $urandom_range(0, 65535));
        near_x = x;
        near_y = y;
        len = w * h;
        // now and then break the stream off early and leave the window open
        if ($urandom_range(0, 7) == 0) len = $urandom_range(0, len - 1);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0) begin
            send_item(KIND_READ, (near_x + $urandom_range(0, 3)) % 128, near_y, 0, 0, 0);
            drawn++;
          end
          send_item(KIND_BITMAP, $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 128), $urandom_range(0, 128),
                    $urandom_range(0, 65535));
        end
        drawn += 1 + len;
      end else if (pick < 75) begin
        if ($urandom_range(0, 1) == 1) begin
          x = (near_x + $urandom_range(0, 3)) % 128;
          y = (near_y + $urandom_range(0, 3)) % 128;
        end
        send_item(KIND_READ, x, y, w, h, $urandom_range(0, 65535));
        drawn++;
      end else if (pick < 90) begin
        send_item(KIND_FLUSH, x, y, w, h, $urandom_range(0, 65535));
        drawn++;
      end else begin
        case ($urandom_range(0, 4))
          0: send_item(KIND_SPARE_LO, x, y, w, h, $urandom_range(0, 65535));
          1: send_item(KIND_SPARE_HI, x, y, w, h, $urandom_range(0, 65535));
          2: send_item(KIND_FILL, x, y, 0, h, $urandom_range(0, 65535));
          3: send_item(KIND_FILL, x, y, w, 0, $urandom_range(0, 65535));
          default: send_item(KIND_WINDOW, x, y, 0, h, $urandom_range(0, 65535));
        endcase
      end
    end
  endtask

  // Result side: stall a random number of cycles before each item, none at
  // all while the calm stretch is on.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    int i, p, sw, sh, en;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_PIXEL;
    in_ch.x_pos       <= '0;
    in_ch.y_pos       <= '0;
    in_ch.rect_width  <= '0;
    in_ch.rect_height <= '0;
    in_ch.color       <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_SCREEN_W;
    cfg_ch.data       <= '0;
    calm = 1'b0;
    hold_next = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Paint the whole buffer first so no later read hits an unwritten pixel.
    send_item(KIND_FILL, 0, 0, 128, 128, 16'hA5A5);
    send_item(KIND_FLUSH, 0, 0, 0, 0, 0);
    // no dirty box left: no answer
    send_item(KIND_FLUSH, 0, 0, 0, 0, 0);
    // opposite corners, extreme colors
    send_item(KIND_PIXEL, 127, 127, 0, 0, 16'hFFFF);
    send_item(KIND_PIXEL, 0, 0, 0, 0, 16'h0000);
    send_item(KIND_READ, 127, 127, 0, 0, 0);
    send_item(KIND_READ, 0, 0, 0, 0, 0);
    // hold off until the reads are back, then flush the corner-to-corner box
    hold_next = 1'b1;
    send_item(KIND_FLUSH, 0, 0, 0, 0, 0);
    // fill running off the right edge; box clips to the buffer
    send_item(KIND_FILL, 125, 3, 128, 2, 16'h1234);
    send_item(KIND_FILL, 5, 5, 0, 10, 16'h5555);
    // bitmap window straddling the edge: off-buffer pixels drop, then it closes
    send_item(KIND_WINDOW, 126, 10, 4, 2, 0);
    for (i = 0; i < 8; i++) send_item(KIND_BITMAP, 0, 0, 0, 0, 16'h0100 + i);
    // bitmap pixel with no window open is ignored
    send_item(KIND_BITMAP, 0, 0, 0, 0, 16'hDEAD);
    // empty window opens nothing
    send_item(KIND_WINDOW, 3, 3, 0, 5, 0);
    send_item(KIND_READ, 127, 11, 0, 0, 0);
    send_item(KIND_SPARE_LO, 1, 1, 1, 1, 1);
    send_item(KIND_SPARE_HI, 1, 1, 1, 1, 1);
    send_item(KIND_FLUSH, 0, 0, 0, 0, 0);

    // Walk through screen settings, extremes included: empty width, empty
    // height, single pixel, full buffer, random sizes, both dirty modes.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin sw = 128; sh = 128; en = 1; end
        1: begin sw = 0;   sh = 128; en = 1; end
        2: begin sw = 128; sh = 0;   en = 0; end
        3: begin sw = 1;   sh = 1;   en = 0; end
        4: begin sw = 128; sh = 128; en = 0; end
        5: begin
          sw = $urandom_range(1, 128);
          sh = $urandom_range(1, 128);
          en = 1;
        end
        6: begin
          sw = $urandom_range(0, 128);
          sh = $urandom_range(0, 128);
          en = $urandom_range(0, 1);
        end
        default: begin sw = 128; sh = 128; en = 1; end
      endcase
      set_screen(sw, sh, en);
      random_burst(PHASE_ITEMS);
    end

    settle();
    $display("covered %0d accepted items over %0d screen settings, dirty tracking on and off",
             items_sent, PHASES);
    $display("compared %0d results against the prediction, %0d mismatches", checked,
             mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(12 * MAX_CYCLES);
    $display("timeout with %0d results outstanding", pending);
    $display("status: fail");
    $finish;
  end

endmodule

### framebuffer_dirty_rect_tracker.f
hw/rtl/fbdr_pkg.sv
hw/rtl/fbdr_if.sv
hw/rtl/fbdr_ctrl.sv
hw/rtl/fbdr_dp.sv
hw/rtl/framebuffer_dirty_rect_tracker.sv
bench/fbdr_checker.sv
bench/tb_framebuffer_dirty_rect_tracker.sv
